FILE: design/u16u8_pkg.sv
// Shared types and constants of the UTF-16LE to UTF-8 transcoder.
// Used by the front-end decoder, the result serializer and the top level.
package u16u8_pkg;

    typedef enum logic [1:0] {
        KIND_UTF8     = 2'd0,
        KIND_ESC_UNIT = 2'd1,
        KIND_ESC_BYTE = 2'd2
    } t_kind;

    localparam int MAX_ITEMS = 4;
    localparam int CAND_SLOTS = 7;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
    localparam logic [7:0]  LEAD_2          = 8'hC0;
    localparam logic [7:0]  LEAD_3          = 8'hE0;
    localparam logic [7:0]  LEAD_4          = 8'hF0;
    localparam logic [7:0]  CONT_MARK       = 8'h80;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        t_item [MAX_ITEMS-1:0] items;
        logic [2:0]            cnt;
        logic                  eon;
        logic                  lossless;
    } t_group;

endpackage

FILE: design/u16u8_front.sv
// Name state registers and per-byte decoder of the transcoder.
// Builds the group of up to four results for each accepted byte.
// Depends on u16u8_pkg.
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_grp_load,
    output u16u8_pkg::t_group o_grp
);
    import u16u8_pkg::*;

    logic [7:0]  r_held_low;
    logic        r_phase;
    logic [15:0] r_pend_unit;
    logic        r_pend_valid;
    logic        r_lossless;

    logic [7:0]  n_held_low;
    logic        n_phase;
    logic [15:0] n_pend_unit;
    logic        n_pend_valid;
    logic        n_lossless;

    logic [15:0] unit;
    logic        is_low;
    logic        is_high;
    logic        pair;
    logic [20:0] cp;
    logic [7:0]  code_bytes [4];
    logic [3:0]  code_en;
    logic        any_esc;

    t_item       cand    [CAND_SLOTS];
    logic [CAND_SLOTS-1:0] cand_en;
    t_group      grp;
    logic [2:0]  cnt;

    assign unit    = {i_data_byte, r_held_low};
    assign is_low  = (unit >= LOW_SURR_FIRST) && (unit <= LOW_SURR_LAST);
    assign is_high = (unit >= HIGH_SURR_FIRST) && (unit <= HIGH_SURR_LAST);
    assign pair    = r_phase && r_pend_valid && is_low;
    assign cp      = SUPP_BASE + {1'b0, r_pend_unit[9:0], unit[9:0]};

    always_comb begin
        code_bytes[0] = 8'h00;
        code_bytes[1] = 8'h00;
        code_bytes[2] = 8'h00;
        code_bytes[3] = 8'h00;
        code_en       = 4'b0000;
        if (pair) begin
            code_bytes[0] = LEAD_4 | {5'b0, cp[20:18]};
            code_bytes[1] = CONT_MARK | {2'b0, cp[17:12]};
            code_bytes[2] = CONT_MARK | {2'b0, cp[11:6]};
            code_bytes[3] = CONT_MARK | {2'b0, cp[5:0]};
            code_en       = 4'b1111;
        end else if (r_phase && unit != 16'h0000 && !is_low && !is_high) begin
            if (unit < ONE_BYTE_LIMIT) begin
                code_bytes[0] = {1'b0, unit[6:0]};
                code_en       = 4'b0001;
            end else if (unit < TWO_BYTE_LIMIT) begin
                code_bytes[0] = LEAD_2 | {3'b0, unit[10:6]};
                code_bytes[1] = CONT_MARK | {2'b0, unit[5:0]};
                code_en       = 4'b0011;
            end else begin
                code_bytes[0] = LEAD_3 | {4'b0, unit[15:12]};
                code_bytes[1] = CONT_MARK | {2'b0, unit[11:6]};
                code_bytes[2] = CONT_MARK | {2'b0, unit[5:0]};
                code_en       = 4'b0111;
            end
        end
    end

    always_comb begin
        cand[0] = '{kind: KIND_ESC_UNIT, value: r_pend_unit};
        cand[1] = '{kind: KIND_UTF8, value: {8'h00, code_bytes[0]}};
        cand[2] = '{kind: KIND_UTF8, value: {8'h00, code_bytes[1]}};
        cand[3] = '{kind: KIND_UTF8, value: {8'h00, code_bytes[2]}};
        cand[4] = '{kind: KIND_UTF8, value: {8'h00, code_bytes[3]}};
        if (r_phase) begin
            cand[5] = '{kind: KIND_ESC_UNIT, value: unit};
        end else begin
            cand[5] = '{kind: KIND_ESC_BYTE, value: {8'h00, i_data_byte}};
        end
        cand[6] = '{kind: KIND_ESC_UNIT, value: unit};

        cand_en[0]   = r_pend_valid && (r_phase ? !is_low : i_last_byte);
        cand_en[4:1] = code_en;
        cand_en[5]   = r_phase ? ((unit == 16'h0000) || (is_low && !r_pend_valid))
                               : i_last_byte;
        cand_en[6]   = r_phase && is_high && i_last_byte;
    end

    assign any_esc = cand_en[0] || cand_en[5] || cand_en[6];

    always_comb begin
        grp      = '0;
        cnt      = 3'd0;
        for (int k = 0; k < CAND_SLOTS; k++) begin
            if (cand_en[k]) begin
                grp.items[cnt[1:0]] = cand[k];
                cnt                 = cnt + 3'd1;
            end
        end
        grp.cnt      = cnt;
        grp.eon      = i_last_byte;
        grp.lossless = r_lossless && !any_esc;
    end

    always_comb begin
        n_held_low   = r_held_low;
        n_phase      = r_phase;
        n_pend_unit  = r_pend_unit;
        n_pend_valid = r_pend_valid;
        n_lossless   = r_lossless && !any_esc;
        if (i_last_byte) begin
            n_held_low   = 8'h00;
            n_phase      = 1'b0;
            n_pend_unit  = 16'h0000;
            n_pend_valid = 1'b0;
            n_lossless   = 1'b1;
        end else if (!r_phase) begin
            n_held_low = i_data_byte;
            n_phase    = 1'b1;
        end else begin
            n_held_low   = 8'h00;
            n_phase      = 1'b0;
            n_pend_valid = is_high && !pair;
            n_pend_unit  = (is_high && !pair) ? unit : 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_low   <= 8'h00;
            r_phase      <= 1'b0;
            r_pend_unit  <= 16'h0000;
            r_pend_valid <= 1'b0;
            r_lossless   <= 1'b1;
        end else if (i_accept) begin
            r_held_low   <= n_held_low;
            r_phase      <= n_phase;
            r_pend_unit  <= n_pend_unit;
            r_pend_valid <= n_pend_valid;
            r_lossless   <= n_lossless;
        end
    end

    assign o_grp_load = i_accept && (cnt != 3'd0);
    assign o_grp      = grp;

    a_pend_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend_unit >= HIGH_SURR_FIRST && r_pend_unit <= HIGH_SURR_LAST))
        else $error("Pending unit is not a high surrogate.");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |-> o_grp_load)
        else $error("Final byte produced no result.");

endmodule

FILE: design/u16u8_serial.sv
// Result group register and output register of the transcoder.
// Sends the results of one group one per cycle while the receiver takes them. Depends on u16u8_pkg.
module u16u8_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_grp_load,
    input  u16u8_pkg::t_group i_grp,
    output logic              o_grp_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_item_kind,
    output logic [15:0]       o_output_value,
    output logic              o_end_of_name,
    output logic              o_lossless
);
    import u16u8_pkg::*;

    t_group      r_grp;
    logic        r_grp_vld;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_value;
    logic        r_eon;
    logic        r_lossless;

    logic        out_load;
    logic        move;
    logic        grp_last;
    t_item       cur;

    assign out_load    = !r_out_valid || i_out_ready;
    assign move        = r_grp_vld && out_load;
    assign grp_last    = ({1'b0, r_idx} == (r_grp.cnt - 3'd1));
    assign o_grp_ready = !r_grp_vld || (move && grp_last);
    assign cur         = r_grp.items[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld   <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_grp_load) begin
                r_grp_vld <= 1'b1;
                r_idx     <= 2'd0;
            end else if (move && grp_last) begin
                r_grp_vld <= 1'b0;
            end else if (move) begin
                r_idx <= r_idx + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= move;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_load) begin
            r_grp <= i_grp;
        end
        if (move) begin
            r_kind     <= cur.kind;
            r_value    <= cur.value;
            r_eon      <= grp_last && r_grp.eon;
            r_lossless <= grp_last && r_grp.eon && r_grp.lossless;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_output_value = r_value;
    assign o_end_of_name  = r_eon;
    assign o_lossless     = r_lossless;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_vld |-> (r_grp.cnt != 3'd0 && r_grp.cnt <= 3'd4))
        else $error("Result group has an impossible count.");

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_vld |-> ({1'b0, r_idx} < r_grp.cnt))
        else $error("Result index runs past the group.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_grp_load && r_grp_vld) |-> (move && grp_last))
        else $error("Result group overwritten before it was sent.");

    a_lossless_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_lossless) |-> r_eon)
        else $error("Lossless flag shown away from the end of a name.");

endmodule

FILE: design/utf16le_to_utf8_transcoder_top.sv
// Top level of the UTF-16LE to UTF-8 name transcoder.
// Instantiates u16u8_front and u16u8_serial; depends on u16u8_pkg.
//
// The input channel takes one raw byte of a little-endian UTF-16 name per
// transaction, with i_last_byte set on the final byte of the name. The output
// channel gives one result per transaction: a UTF-8 byte, an escaped code unit
// or an escaped trailing odd byte, as told by o_item_kind. The last result of a
// name carries o_end_of_name, and with it o_lossless reports whether the name
// needed no escape.
// Each accepted byte produces zero to four results. They are built
// combinationally into a group register and then leave one per cycle, while
// the receiver is ready, through the output register; the first result of a
// byte passes the group register and then the output register. A byte is
// accepted in every cycle in which the group register is empty or sends its
// final result. A code unit that needs three UTF-8 bytes gives three results.
// When the receiver stalls, the output register holds its result and the group
// register fills, after which o_in_ready falls. Reset empties both registers
// and returns the name state to the start of a name.
module utf16le_to_utf8_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_output_value,
    output logic        o_end_of_name,
    output logic        o_lossless
);
    import u16u8_pkg::*;

    logic   grp_ready;
    logic   grp_load;
    logic   accept;
    t_group grp;

    assign accept     = i_in_valid && grp_ready;
    assign o_in_ready = grp_ready;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_grp_load  (grp_load),
        .o_grp       (grp)
    );

    u16u8_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grp_load     (grp_load),
        .i_grp          (grp),
        .o_grp_ready    (grp_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_item_kind    (o_item_kind),
        .o_output_value (o_output_value),
        .o_end_of_name  (o_end_of_name),
        .o_lossless     (o_lossless)
    );

endmodule
